/* rtl/assert_macros.svh */
// Assertion helpers for the quaternion pipeline.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define E2Q_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Overlapping implication checked outside reset.
`define E2Q_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) else $error(msg);

`endif

/* rtl/e2q_pkg.sv */
package e2q_pkg;

  localparam int SERIES_TERMS = 7;
  localparam int STEP_LATENCY = 3;
  // F1 reduce, F2 square, F3 round, series steps, final sign register
  localparam int LANE_LATENCY = 4 + STEP_LATENCY * SERIES_TERMS;
  localparam int MERGE_LATENCY = 5;
  localparam int TOTAL_LATENCY = LANE_LATENCY + MERGE_LATENCY;

  localparam logic [63:0] Q30_HALF = 64'd536870912;
  localparam logic [30:0] Q30_ONE = 31'd1073741824;
  localparam logic [31:0] PI_Q30 = 32'd3373259426;
  localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;

  // Sine and cosine of one half angle, sign and magnitude in Q2.30.
  typedef struct packed {
    logic        sin_neg;
    logic [31:0] sin_mag;
    logic        cos_neg;
    logic [31:0] cos_mag;
  } half_trig_t;

  function automatic int sin_div(input int k);
    return (2 * k) * (2 * k + 1);
  endfunction

  function automatic int cos_div(input int k);
    return (2 * k - 1) * (2 * k);
  endfunction

endpackage

/* rtl/e2q_step.sv */
module e2q_step #(
  parameter int DIVISOR = 6,
  parameter bit SUBTRACT = 1'b1
) (
  input  logic               clk,
  input  logic [30:0]        term_in,
  input  logic [31:0]        x2_in,
  input  logic signed [32:0] acc_in,
  output logic [30:0]        term_out,
  output logic [31:0]        x2_out,
  output logic signed [32:0] acc_out
);
  import e2q_pkg::*;

  // floor(2^32 / d); quotient estimate is exact or one low
  localparam logic [31:0] RECIP = 32'(64'h1_0000_0000 / DIVISOR);
  localparam logic [31:0] DIV_W = 32'(DIVISOR);

  logic [63:0]        prod;
  logic [31:0]        x2_a;
  logic signed [32:0] acc_a;
  logic [63:0]        recip_prod;
  logic [31:0]        numer;
  logic [31:0]        x2_b;
  logic signed [32:0] acc_b;
  logic [63:0]        rounded;
  logic [30:0]        q_est;
  logic [33:0]        remain;
  logic [30:0]        quot;

  always_comb begin
    rounded = prod + Q30_HALF;
    q_est = recip_prod[62:32];
    remain = {2'b00, numer} - 34'({31'd0, q_est} * {32'd0, DIV_W});
    quot = (remain >= {2'b00, DIV_W}) ? q_est + 31'd1 : q_est;
  end

  always_ff @(posedge clk) begin
    prod <= {33'd0, term_in} * {32'd0, x2_in};
    x2_a <= x2_in;
    acc_a <= acc_in;

    numer <= rounded[61:30];
    recip_prod <= {32'd0, rounded[61:30]} * {32'd0, RECIP};
    x2_b <= x2_a;
    acc_b <= acc_a;

    term_out <= quot;
    x2_out <= x2_b;
    acc_out <= SUBTRACT ? acc_b - $signed({2'b00, quot}) : acc_b + $signed({2'b00, quot});
  end

endmodule

/* rtl/e2q_lane.sv */
module e2q_lane #(
  parameter int ANGLE_WIDTH = 16
) (
  input  logic                   clk,
  input  logic [ANGLE_WIDTH-1:0] angle,
  output e2q_pkg::half_trig_t    trig
);
  import e2q_pkg::*;

  localparam int FLAG_DEPTH = 3 + STEP_LATENCY * SERIES_TERMS;

  logic signed [31:0] half_ang;
  logic [31:0]        abs_ang;
  logic [31:0]        red_ang;
  logic               fold;

  logic [30:0] m_r;
  logic [30:0] m_d;
  logic [30:0] m_d2;
  logic [61:0] sq;
  logic [63:0] sq_rnd;
  logic [31:0] x2;
  logic [FLAG_DEPTH-1:0] neg_dly;
  logic [FLAG_DEPTH-1:0] flip_dly;

  logic [30:0]        s_term [SERIES_TERMS+1];
  logic [31:0]        s_x2   [SERIES_TERMS+1];
  logic signed [32:0] s_acc  [SERIES_TERMS+1];
  logic [30:0]        c_term [SERIES_TERMS+1];
  logic [31:0]        c_x2   [SERIES_TERMS+1];
  logic signed [32:0] c_acc  [SERIES_TERMS+1];

  logic signed [32:0] s_fin;
  logic signed [32:0] c_fin;

  // half angle in Q2.30 is the code shifted up
  always_comb begin
    half_ang = 32'(signed'(angle)) <<< (32 - ANGLE_WIDTH);
    abs_ang = half_ang[31] ? 32'd0 - half_ang : half_ang;
    fold = abs_ang > HALF_PI_Q30;
    red_ang = fold ? PI_Q30 - abs_ang : abs_ang;
    sq_rnd = {2'b00, sq} + Q30_HALF;
  end

  always_ff @(posedge clk) begin
    m_r <= red_ang[30:0];
    neg_dly <= {neg_dly[FLAG_DEPTH-2:0], half_ang[31]};
    flip_dly <= {flip_dly[FLAG_DEPTH-2:0], fold};
    sq <= {31'd0, m_r} * {31'd0, m_r};
    m_d <= m_r;
    x2 <= sq_rnd[61:30];
    m_d2 <= m_d;
  end

  assign s_term[0] = m_d2;
  assign s_x2[0] = x2;
  assign s_acc[0] = $signed({2'b00, m_d2});
  assign c_term[0] = Q30_ONE;
  assign c_x2[0] = x2;
  assign c_acc[0] = $signed({2'b00, Q30_ONE});

  for (genvar i = 0; i < SERIES_TERMS; i++) begin : g_term
    e2q_step #(.DIVISOR(sin_div(i + 1)), .SUBTRACT(((i + 1) % 2) == 1)) u_sin (
      .clk(clk), .term_in(s_term[i]), .x2_in(s_x2[i]), .acc_in(s_acc[i]),
      .term_out(s_term[i+1]), .x2_out(s_x2[i+1]), .acc_out(s_acc[i+1])
    );
    e2q_step #(.DIVISOR(cos_div(i + 1)), .SUBTRACT(((i + 1) % 2) == 1)) u_cos (
      .clk(clk), .term_in(c_term[i]), .x2_in(c_x2[i]), .acc_in(c_acc[i]),
      .term_out(c_term[i+1]), .x2_out(c_x2[i+1]), .acc_out(c_acc[i+1])
    );
  end

  assign s_fin = s_acc[SERIES_TERMS];
  assign c_fin = c_acc[SERIES_TERMS];

  // sign of a zero magnitude is don't-care downstream
  always_ff @(posedge clk) begin
    trig.sin_neg <= neg_dly[FLAG_DEPTH-1] ^ s_fin[32];
    trig.sin_mag <= s_fin[32] ? 32'(-s_fin) : s_fin[31:0];
    trig.cos_neg <= flip_dly[FLAG_DEPTH-1] ^ c_fin[32];
    trig.cos_mag <= c_fin[32] ? 32'(-c_fin) : c_fin[31:0];
  end

endmodule

/* rtl/e2q_merge.sv */
module e2q_merge #(
  parameter int OUT_WIDTH = 16
) (
  input  logic                       clk,
  input  e2q_pkg::half_trig_t        roll,
  input  e2q_pkg::half_trig_t        pitch,
  input  e2q_pkg::half_trig_t        yaw,
  output logic signed [OUT_WIDTH-1:0] w_out,
  output logic signed [OUT_WIDTH-1:0] x_out,
  output logic signed [OUT_WIDTH-1:0] y_out,
  output logic signed [OUT_WIDTH-1:0] z_out
);
  import e2q_pkg::*;

  localparam int SHIFT = 32 - OUT_WIDTH;
  localparam logic [34:0] RND = (35'd1 << SHIFT) >> 1;
  localparam logic [34:0] LIMIT = 35'd1 << (OUT_WIDTH - 2);

  // stage 1: yaw/pitch cross products
  logic [63:0] p1 [4];
  logic        n1 [4];
  half_trig_t  roll_1;
  // stage 2: rounded
  logic [31:0] m2 [4];
  logic        n2 [4];
  half_trig_t  roll_2;
  // stage 3: products with roll terms
  logic [63:0] p3 [8];
  logic        n3 [8];
  // stage 4: signed sums
  logic signed [34:0] sum4 [4];

  logic [63:0]        rnd1 [4];
  logic [63:0]        rnd3 [8];
  logic signed [33:0] val3 [8];
  logic [31:0]        mb3  [8];
  logic               nb3  [8];
  logic [31:0]        ma3  [8];
  logic               na3  [8];

  // pair order: cycp, sysp, sycp, cysp
  always_ff @(posedge clk) begin
    p1[0] <= {32'd0, yaw.cos_mag} * {32'd0, pitch.cos_mag};
    n1[0] <= yaw.cos_neg ^ pitch.cos_neg;
    p1[1] <= {32'd0, yaw.sin_mag} * {32'd0, pitch.sin_mag};
    n1[1] <= yaw.sin_neg ^ pitch.sin_neg;
    p1[2] <= {32'd0, yaw.sin_mag} * {32'd0, pitch.cos_mag};
    n1[2] <= yaw.sin_neg ^ pitch.cos_neg;
    p1[3] <= {32'd0, yaw.cos_mag} * {32'd0, pitch.sin_mag};
    n1[3] <= yaw.cos_neg ^ pitch.sin_neg;
    roll_1 <= roll;
    roll_2 <= roll_1;
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      rnd1[i] = p1[i] + Q30_HALF;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      m2[i] <= rnd1[i][61:30];
      n2[i] <= n1[i];
    end
  end

  // product order: w: cycp*cr, sysp*sr; x: cycp*sr, sysp*cr;
  // y: sycp*sr, cysp*cr; z: sycp*cr, cysp*sr
  always_comb begin
    ma3[0] = m2[0]; na3[0] = n2[0]; mb3[0] = roll_2.cos_mag; nb3[0] = roll_2.cos_neg;
    ma3[1] = m2[1]; na3[1] = n2[1]; mb3[1] = roll_2.sin_mag; nb3[1] = roll_2.sin_neg;
    ma3[2] = m2[0]; na3[2] = n2[0]; mb3[2] = roll_2.sin_mag; nb3[2] = roll_2.sin_neg;
    ma3[3] = m2[1]; na3[3] = n2[1]; mb3[3] = roll_2.cos_mag; nb3[3] = roll_2.cos_neg;
    ma3[4] = m2[2]; na3[4] = n2[2]; mb3[4] = roll_2.sin_mag; nb3[4] = roll_2.sin_neg;
    ma3[5] = m2[3]; na3[5] = n2[3]; mb3[5] = roll_2.cos_mag; nb3[5] = roll_2.cos_neg;
    ma3[6] = m2[2]; na3[6] = n2[2]; mb3[6] = roll_2.cos_mag; nb3[6] = roll_2.cos_neg;
    ma3[7] = m2[3]; na3[7] = n2[3]; mb3[7] = roll_2.sin_mag; nb3[7] = roll_2.sin_neg;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 8; i++) begin
      p3[i] <= {32'd0, ma3[i]} * {32'd0, mb3[i]};
      n3[i] <= na3[i] ^ nb3[i];
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      rnd3[i] = p3[i] + Q30_HALF;
      val3[i] = n3[i] ? -$signed({2'b00, rnd3[i][61:30]}) : $signed({2'b00, rnd3[i][61:30]});
    end
  end

  always_ff @(posedge clk) begin
    sum4[0] <= 35'(val3[0]) + 35'(val3[1]);
    sum4[1] <= 35'(val3[2]) - 35'(val3[3]);
    sum4[2] <= 35'(val3[4]) + 35'(val3[5]);
    sum4[3] <= 35'(val3[6]) - 35'(val3[7]);
  end

  // round half away from zero, clamp to +/-1.0
  function automatic logic [OUT_WIDTH-1:0] to_out(input logic signed [34:0] v);
    logic [34:0] mag;
    logic [34:0] rmag;
    mag = v[34] ? 35'(-v) : v;
    rmag = (mag + RND) >> SHIFT;
    if (rmag > LIMIT) begin
      rmag = LIMIT;
    end
    return v[34] ? OUT_WIDTH'(-rmag) : rmag[OUT_WIDTH-1:0];
  endfunction

  always_ff @(posedge clk) begin
    w_out <= to_out(sum4[0]);
    x_out <= to_out(sum4[1]);
    y_out <= to_out(sum4[2]);
    z_out <= to_out(sum4[3]);
  end

endmodule

/* rtl/euler_to_quaternion.sv */
// Pipeline: the start beat runs down a valid shift register beside the
//   sine/cosine lanes and the quaternion merge and emerges as done.
// Throughput: one angle set per cycle; busy is never raised.
// Reset: synchronous, active high; clears the in-flight valid pipeline so
//   no stale done strobe appears. The receiver cannot stall the results.
module euler_to_quaternion #(
  parameter int ANGLE_WIDTH = 16,
  parameter int OUT_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [ANGLE_WIDTH-1:0] roll_angle,
  input  logic signed [ANGLE_WIDTH-1:0] pitch_angle,
  input  logic signed [ANGLE_WIDTH-1:0] yaw_angle,
  output logic                          done,
  output logic signed [OUT_WIDTH-1:0]   w_component,
  output logic signed [OUT_WIDTH-1:0]   x_component,
  output logic signed [OUT_WIDTH-1:0]   y_component,
  output logic signed [OUT_WIDTH-1:0]   z_component
);
  import e2q_pkg::*;
  `include "assert_macros.svh"

  localparam logic signed [OUT_WIDTH-1:0] OUT_MAX = OUT_WIDTH'(1) <<< (OUT_WIDTH - 2);
  localparam logic signed [OUT_WIDTH-1:0] OUT_MIN = -OUT_MAX;

  half_trig_t roll_trig;
  half_trig_t pitch_trig;
  half_trig_t yaw_trig;

  // valid bit per pipeline stage; payload flows unqualified beside it
  logic [TOTAL_LATENCY-1:0] valid;

  // fully pipelined: every stage advances each cycle
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[TOTAL_LATENCY-2:0], start & ~busy};
    end
  end

  assign done = valid[TOTAL_LATENCY-1];

  // three identical lanes: half angle, range fold, Taylor series per angle
  e2q_lane #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_roll (
    .clk(clk), .angle(roll_angle), .trig(roll_trig)
  );
  e2q_lane #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_pitch (
    .clk(clk), .angle(pitch_angle), .trig(pitch_trig)
  );
  e2q_lane #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_yaw (
    .clk(clk), .angle(yaw_angle), .trig(yaw_trig)
  );

  // ZYX combine, rounding and clamp to +/-1.0
  e2q_merge #(.OUT_WIDTH(OUT_WIDTH)) u_merge (
    .clk(clk), .roll(roll_trig), .pitch(pitch_trig), .yaw(yaw_trig),
    .w_out(w_component), .x_out(x_component),
    .y_out(y_component), .z_out(z_component)
  );

  `E2Q_ASSERT_IMP(a_start_gives_done, start && !busy, ##TOTAL_LATENCY done, "beat lost in pipeline")
  `E2Q_ASSERT_IMP(a_done_has_start, done, $past(start, TOTAL_LATENCY), "done without a start beat")
  `E2Q_ASSERT(a_wx_clamped, !done || ((w_component <= OUT_MAX) && (w_component >= OUT_MIN) && (x_component <= OUT_MAX) && (x_component >= OUT_MIN)), "w/x beyond unit range")
  `E2Q_ASSERT(a_yz_clamped, !done || ((y_component <= OUT_MAX) && (y_component >= OUT_MIN) && (z_component <= OUT_MAX) && (z_component >= OUT_MIN)), "y/z beyond unit range")

endmodule
